// File: src/array_insert_with_statistics_assert.svh
// Assertion helpers for the files that check their own logic.
// Each expects signals named clock and reset in the module that uses it.
`ifndef ARRAY_INSERT_WITH_STATISTICS_ASSERT_SVH
`define ARRAY_INSERT_WITH_STATISTICS_ASSERT_SVH

// Same-cycle implication.
`define AIWS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define AIWS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/aiws_pkg.sv
package aiws_pkg;

   localparam int DEPTH_DEFAULT = 128;

   localparam int REQ_BITS   = 42;
   localparam int REQ_BYTES  = (REQ_BITS + 7) / 8;
   localparam int RSP_BITS   = 147;
   localparam int RSP_BYTES  = (RSP_BITS + 7) / 8;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRIME,
      S_WRITE,
      S_SCAN,
      S_FLUSH
   } ctl_state_type;

   typedef enum logic [1:0] {
      P_IDLE,
      P_CHECK,
      P_DIV,
      P_DONE
   } prime_state_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic write;   // apply the pending insert or append
      logic shift;   // insert below the fill count: move later entries up
      logic rotate;  // scan step: every cell takes its upper neighbor
   } cell_cmd_type;

endpackage

// File: src/aiws_cell.sv
module aiws_cell #(
   parameter int DEPTH = aiws_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  aiws_pkg::cell_cmd_type     cmd,
   input  logic [$clog2(DEPTH)-1:0]   write_pos,
   input  logic [$clog2(DEPTH+1)-1:0] fill,
   input  logic [31:0]                new_value,
   input  logic                       new_prime,
   input  logic [31:0]                prev_value,
   input  logic                       prev_prime,
   input  logic [31:0]                next_value,
   input  logic                       next_prime,
   output logic [31:0]                value,
   output logic                       prime
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic [31:0] value_ff, value_in;
   logic        prime_ff, prime_in;
   logic [CW-1:0] pos;

   assign pos = CW'(write_pos);

   always_comb begin
      value_in = value_ff;
      prime_in = prime_ff;
      if (cmd.rotate) begin
         value_in = next_value;
         prime_in = next_prime;
      end else if (cmd.write) begin
         if (IDX == pos) begin
            value_in = new_value;
            prime_in = new_prime;
         end else if (cmd.shift && IDX > pos && IDX <= fill) begin
            value_in = prev_value;
            prime_in = prev_prime;
         end else if (!cmd.shift && IDX >= fill && IDX < pos) begin
            // Gap between the old fill count and the insert position.
            value_in = '0;
            prime_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prime_ff <= prime_in;
   end

   assign value = value_ff;
   assign prime = prime_ff;

endmodule

// File: src/aiws_prime.sv
module aiws_prime (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output logic        is_prime
);

   aiws_pkg::prime_state_type state_ff, state_in;

   logic [31:0] n_ff;
   logic [16:0] j_ff;
   logic [31:0] sq_ff;
   logic [16:0] rem_ff;
   logic [4:0]  bit_ff;
   logic        prime_ff;

   logic [17:0] rem_shift;
   logic [17:0] rem_sub;
   logic [16:0] rem_next;

   assign rem_shift = {rem_ff, n_ff[bit_ff]};
   assign rem_sub   = rem_shift - {1'b0, j_ff};
   assign rem_next  = (rem_shift >= {1'b0, j_ff}) ? rem_sub[16:0] : rem_shift[16:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aiws_pkg::P_IDLE: begin
            if (start) begin
               state_in = ($signed(value) < 32'sd2) ? aiws_pkg::P_DONE : aiws_pkg::P_CHECK;
            end
         end
         aiws_pkg::P_CHECK: begin
            state_in = (sq_ff > n_ff) ? aiws_pkg::P_DONE : aiws_pkg::P_DIV;
         end
         aiws_pkg::P_DIV: begin
            if (bit_ff == 5'd0) begin
               state_in = (rem_next == '0) ? aiws_pkg::P_DONE : aiws_pkg::P_CHECK;
            end
         end
         aiws_pkg::P_DONE: state_in = aiws_pkg::P_IDLE;
         default:          state_in = aiws_pkg::P_IDLE;
      endcase
   end

   always_comb begin
      done     = (state_ff == aiws_pkg::P_DONE);
      is_prime = prime_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aiws_pkg::P_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Trial division: j runs from 2 while j*j <= n, each remainder by a
   // restoring divider one bit a cycle; j*j is kept by adding 2j+1.
   always_ff @(posedge clock) begin
      case (state_ff)
         aiws_pkg::P_IDLE: begin
            n_ff     <= value;
            j_ff     <= 17'd2;
            sq_ff    <= 32'd4;
            prime_ff <= 1'b0;
         end
         aiws_pkg::P_CHECK: begin
            rem_ff <= '0;
            bit_ff <= 5'd31;
            if (sq_ff > n_ff) begin
               prime_ff <= 1'b1;
            end
         end
         aiws_pkg::P_DIV: begin
            rem_ff <= rem_next;
            bit_ff <= bit_ff - 5'd1;
            if (bit_ff == 5'd0) begin
               sq_ff <= sq_ff + 32'({j_ff, 1'b1});
               j_ff  <= j_ff + 17'd1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: src/array_insert_with_statistics.sv
// Table of signed 32-bit entries with insert, append and query, reporting
// statistics after every item.
// Input channel req_*: one transfer per item (func, value, position).
// Result channel rsp_*: exactly one transfer per item, in item order.
// The entries sit in a row of cells. A write first runs the value through
// a trial-division prime unit (a value below 2 skips the divisions; otherwise
// each divisor takes a check of j*j against n and a bit-serial division),
// then updates the row in the S_WRITE state (shift up, or zero-fill a gap).
// Every item then rotates the row once around while the statistics are
// gathered at cell zero.
// rsp_tvalid rises once the scan ends and S_FLUSH loads the output register;
// for a write the prime test and S_WRITE come before the scan.
// One item is in work at a time.
// The result sits in an output register, so the next item is accepted while
// the previous result still waits; a stalled receiver only holds the block
// at the end of the following scan.
// Reset empties the table at once (fill count zero); no clearing pass.
module array_insert_with_statistics #(
   parameter int DEPTH = aiws_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] func, [33:2] value, [41:34] position
   input  logic [aiws_pkg::REQ_BYTES*8-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [9:2] fill_count, [41:10] even_sum, [73:42] min_value,
   // [105:74] max_value, [137:106] prime_sum, [145:138] match_count,
   // [146] is_empty
   output logic [aiws_pkg::RSP_BYTES*8-1:0] rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] LAST_SCAN = CW'(DEPTH - 1);

   logic [1:0]  req_func;
   logic [31:0] req_value;
   logic [7:0]  req_position;
   logic        req_accept;

   assign req_func     = req_tdata[1:0];
   assign req_value    = req_tdata[33:2];
   assign req_position = req_tdata[41:34];
   assign req_accept   = req_tvalid && req_tready;

   aiws_pkg::ctl_state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] new_count_ff;
   logic [IW-1:0] wpos_ff;
   logic          shift_ff;
   logic [1:0]    status_ff;
   logic [31:0]   key_ff;
   logic [CW-1:0] scan_ff;

   // Decode of the item at the input.
   logic [1:0]    dec_status;
   logic          dec_write;
   logic          dec_shift;
   logic [IW-1:0] dec_pos;
   logic [CW-1:0] dec_count;
   logic [31:0]   pos_wide;
   logic [31:0]   cnt_wide;

   assign pos_wide = 32'(req_position);
   assign cnt_wide = 32'(count_ff);

   always_comb begin
      dec_status = aiws_pkg::STATUS_DONE;
      dec_write  = 1'b0;
      dec_shift  = 1'b0;
      dec_pos    = count_ff[IW-1:0];
      dec_count  = count_ff;
      case (req_func)
         aiws_pkg::FUNC_APPEND: begin
            if (count_ff >= FULL_COUNT) begin
               dec_status = aiws_pkg::STATUS_FULL;
            end else begin
               dec_write = 1'b1;
               dec_count = count_ff + CW'(1);
            end
         end
         aiws_pkg::FUNC_INSERT: begin
            dec_pos = pos_wide[IW-1:0];
            if (pos_wide >= 32'(DEPTH - 1)) begin
               dec_status = aiws_pkg::STATUS_RANGE;
            end else if (pos_wide >= cnt_wide) begin
               dec_write = 1'b1;
               dec_count = pos_wide[CW-1:0] + CW'(1);
            end else if (count_ff >= FULL_COUNT) begin
               dec_status = aiws_pkg::STATUS_FULL;
            end else begin
               dec_write = 1'b1;
               dec_shift = 1'b1;
               dec_count = count_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   logic prime_done;
   logic prime_flag;

   aiws_prime u_prime (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept && dec_write),
      .value    (req_value),
      .done     (prime_done),
      .is_prime (prime_flag)
   );

   aiws_pkg::cell_cmd_type cmd;
   logic [31:0] cell_value [DEPTH];
   logic        cell_prime [DEPTH];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      localparam int PREV = (g + DEPTH - 1) % DEPTH;
      localparam int NEXT = (g + 1) % DEPTH;
      aiws_cell #(
         .DEPTH (DEPTH),
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .write_pos  (wpos_ff),
         .fill       (count_ff),
         .new_value  (key_ff),
         .new_prime  (prime_flag),
         .prev_value (cell_value[PREV]),
         .prev_prime (cell_prime[PREV]),
         .next_value (cell_value[NEXT]),
         .next_prime (cell_prime[NEXT]),
         .value      (cell_value[g]),
         .prime      (cell_prime[g])
      );
   end

   // Statistics gathered from cell zero while the row rotates.
   logic [31:0]   even_ff, even_in;
   logic [31:0]   psum_ff, psum_in;
   logic [31:0]   min_ff, min_in;
   logic [31:0]   max_ff, max_in;
   logic [CW-1:0] match_ff, match_in;
   logic [31:0]   head;
   logic          head_valid;
   logic          first;

   assign head       = cell_value[0];
   assign head_valid = scan_ff < count_ff;
   assign first      = (scan_ff == '0);

   always_comb begin
      even_in  = first ? '0 : even_ff;
      psum_in  = first ? '0 : psum_ff;
      min_in   = first ? '0 : min_ff;
      max_in   = first ? '0 : max_ff;
      match_in = first ? '0 : match_ff;
      if (head_valid) begin
         if (!head[0]) begin
            even_in = even_in + head;
         end
         if (cell_prime[0]) begin
            psum_in = psum_in + head;
         end
         if (head == key_ff) begin
            match_in = match_in + CW'(1);
         end
         if (first || $signed(head) < $signed(min_ff)) begin
            min_in = head;
         end
         if (first || $signed(head) > $signed(max_ff)) begin
            max_in = head;
         end
      end
   end

   logic rsp_valid_ff;
   logic [aiws_pkg::RSP_BYTES*8-1:0] rsp_data_ff;
   logic slot_free;
   logic load_rsp;
   logic [31:0] count_out;
   logic [31:0] match_out;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign count_out = 32'(count_ff);
   assign match_out = 32'(match_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aiws_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = dec_write ? aiws_pkg::S_PRIME : aiws_pkg::S_SCAN;
            end
         end
         aiws_pkg::S_PRIME: begin
            if (prime_done) begin
               state_in = aiws_pkg::S_WRITE;
            end
         end
         aiws_pkg::S_WRITE: state_in = aiws_pkg::S_SCAN;
         aiws_pkg::S_SCAN: begin
            if (scan_ff == LAST_SCAN) begin
               state_in = aiws_pkg::S_FLUSH;
            end
         end
         aiws_pkg::S_FLUSH: begin
            if (slot_free) begin
               state_in = aiws_pkg::S_IDLE;
            end
         end
         default: state_in = aiws_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == aiws_pkg::S_IDLE) && !reset;
      cmd.write  = (state_ff == aiws_pkg::S_WRITE);
      cmd.shift  = shift_ff;
      cmd.rotate = (state_ff == aiws_pkg::S_SCAN);
      load_rsp   = (state_ff == aiws_pkg::S_FLUSH) && slot_free;
      count_in   = (state_ff == aiws_pkg::S_WRITE) ? new_count_ff : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aiws_pkg::S_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == aiws_pkg::S_SCAN) begin
            scan_ff <= (scan_ff == LAST_SCAN) ? '0 : scan_ff + CW'(1);
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         key_ff       <= req_value;
         status_ff    <= dec_status;
         shift_ff     <= dec_shift;
         wpos_ff      <= dec_pos;
         new_count_ff <= dec_count;
      end
      if (state_ff == aiws_pkg::S_SCAN) begin
         even_ff  <= even_in;
         psum_ff  <= psum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         match_ff <= match_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= {5'd0, (count_ff == '0), match_out[7:0], psum_ff, max_ff,
                         min_ff, even_ff, count_out[7:0], status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `include "array_insert_with_statistics_assert.svh"

   `AIWS_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= FULL_COUNT, "fill count above depth")
   `AIWS_ASSERT_NXT(a_scan_count, state_ff == aiws_pkg::S_SCAN, $stable(count_ff),
                    "fill count changed during scan")
   `AIWS_ASSERT_IMP(a_prime_state, prime_done, state_ff == aiws_pkg::S_PRIME,
                    "prime result outside prime wait")
   `AIWS_ASSERT_NXT(a_write_path, req_accept && dec_write, state_ff == aiws_pkg::S_PRIME,
                    "write item did not start prime test")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// One expected or observed result transfer, in the order of the rsp_tdata fields.
typedef struct packed {
   logic        is_empty;
   logic [7:0]  match_count;
   logic [31:0] prime_sum;
   logic [31:0] max_value;
   logic [31:0] min_value;
   logic [31:0] even_sum;
   logic [7:0]  fill_count;
   logic [1:0]  status;
} table_stats_type;

class table_scoreboard;
   localparam int DEPTH = aiws_pkg::DEPTH_DEFAULT;

   logic [31:0]     table_data [DEPTH];
   bit              table_prime [DEPTH];
   int              fill;
   table_stats_type pending_stats [$];
   int              mismatches;
   int              results_seen;
   int              items_seen;

   function new();
      fill = 0;
      mismatches = 0;
      results_seen = 0;
      items_seen = 0;
   endfunction

   // Trial division over the signed value; anything below 2 is not prime.
   function bit is_prime(logic [31:0] bits);
      longint n;
      longint j;
      n = longint'($signed(bits));
      if (n < 2) return 0;
      for (j = 2; j * j <= n; j++)
         if (n % j == 0) return 0;
      return 1;
   endfunction

   function void store(int idx, logic [31:0] v);
      table_data[idx] = v;
      table_prime[idx] = is_prime(v);
   endfunction

   // Applies one accepted item and queues the statistics it must produce.
   function void note_item(logic [1:0] func, logic [31:0] v, logic [7:0] pos);
      table_stats_type s;
      int i;
      s = '0;
      items_seen++;
      if (func == aiws_pkg::FUNC_APPEND) begin
         if (fill >= DEPTH) begin
            s.status = aiws_pkg::STATUS_FULL;
         end else begin
            store(fill, v);
            fill++;
         end
      end else if (func == aiws_pkg::FUNC_INSERT) begin
         if (int'(pos) >= DEPTH - 1) begin
            s.status = aiws_pkg::STATUS_RANGE;
         end else if (int'(pos) >= fill) begin
            for (i = fill; i < int'(pos); i++) store(i, '0);
            store(int'(pos), v);
            fill = int'(pos) + 1;
         end else if (fill >= DEPTH) begin
            s.status = aiws_pkg::STATUS_FULL;
         end else begin
            for (i = fill; i > int'(pos); i--) begin
               table_data[i] = table_data[i - 1];
               table_prime[i] = table_prime[i - 1];
            end
            store(int'(pos), v);
            fill++;
         end
      end
      for (i = 0; i < fill; i++) begin
         if (!table_data[i][0]) s.even_sum += table_data[i];
         if (table_prime[i]) s.prime_sum += table_data[i];
         if (table_data[i] == v) s.match_count++;
         if (i == 0 || $signed(table_data[i]) < $signed(s.min_value))
            s.min_value = table_data[i];
         if (i == 0 || $signed(table_data[i]) > $signed(s.max_value))
            s.max_value = table_data[i];
      end
      s.fill_count = fill[7:0];
      s.is_empty = (fill == 0);
      pending_stats.push_back(s);
   endfunction

   function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch in %s at result %0d: expected %h, got %h",
                  field, results_seen, want, got);
   endfunction

   function void check_result(table_stats_type got);
      table_stats_type want;
      results_seen++;
      if (pending_stats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result transfer %0d", results_seen);
         return;
      end
      want = pending_stats.pop_front();
      if (got.status !== want.status)
         report("status", 32'(want.status), 32'(got.status));
      if (got.fill_count !== want.fill_count)
         report("fill_count", 32'(want.fill_count), 32'(got.fill_count));
      if (got.even_sum !== want.even_sum) report("even_sum", want.even_sum, got.even_sum);
      if (got.min_value !== want.min_value)
         report("min_value", want.min_value, got.min_value);
      if (got.max_value !== want.max_value)
         report("max_value", want.max_value, got.max_value);
      if (got.prime_sum !== want.prime_sum)
         report("prime_sum", want.prime_sum, got.prime_sum);
      if (got.match_count !== want.match_count)
         report("match_count", 32'(want.match_count), 32'(got.match_count));
      if (got.is_empty !== want.is_empty)
         report("is_empty", 32'(want.is_empty), 32'(got.is_empty));
   endfunction
endclass

module tb;
   localparam logic [1:0] FUNC_QUERY   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;
   localparam int         RANDOM_ITEMS = 1000;
   localparam longint     CYCLE_LIMIT  = 8000000;

   logic                             clock = 0;
   logic                             reset = 1;
   logic                             req_tvalid = 0;
   logic                             req_tready;
   logic [aiws_pkg::REQ_BYTES*8-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 0;
   logic [aiws_pkg::RSP_BYTES*8-1:0] rsp_tdata;

   table_scoreboard stats_board = new();
   longint          cycle_count = 0;
   logic [31:0]     last_value = 0;
   bit              hold_ready = 0;

   array_insert_with_statistics DUT (.*);

   always #6 clock = ~clock;

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // Large positive values are kept composite so the prime unit stays fast.
   function logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return $urandom_range(0, 200);
      if (r < 62) return {1'b1, 31'($urandom())};
      if (r < 72) return {1'b0, 30'($urandom()), 1'b0};
      if (r < 82) return 32'($urandom_range(0, 715827882)) * 3;
      return last_value;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver side: random stalls, and transfers checked in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            stats_board.check_result(rsp_tdata[aiws_pkg::RSP_BITS-1:0]);
         if (hold_ready) rsp_tready <= 1;
         else if (rsp_tready) rsp_tready <= ($urandom_range(0, 99) < 80);
         else rsp_tready <= (pick_gap() == 0);
      end
      if (!reset && req_tvalid && req_tready)
         stats_board.note_item(req_tdata[1:0], req_tdata[33:2], req_tdata[41:34]);
   end

   task send_item(logic [1:0] func, logic [31:0] v, logic [7:0] pos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'd0, pos, v, func};
      last_value = v;
      do @(posedge clock); while (!req_tready);
   endtask

   task wait_drained();
      do @(posedge clock); while (stats_board.pending_stats.size() != 0);
   endtask

   initial begin
      int r;
      logic [1:0] func;
      logic [7:0] pos;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(FUNC_QUERY, 32'h8000_0000, 0);
      send_item(aiws_pkg::FUNC_APPEND, 32'h8000_0000, 0);
      send_item(aiws_pkg::FUNC_APPEND, 32'hFFFF_FFFF, 255);
      send_item(aiws_pkg::FUNC_APPEND, 0, 0);
      send_item(aiws_pkg::FUNC_APPEND, 2, 0);
      send_item(aiws_pkg::FUNC_APPEND, 7, 0);
      send_item(aiws_pkg::FUNC_APPEND, 32'h7FFF_FFFE, 0);
      send_item(aiws_pkg::FUNC_APPEND, 1, 0);
      send_item(aiws_pkg::FUNC_INSERT, 97, 0);
      send_item(aiws_pkg::FUNC_INSERT, 32'hFFFF_FFF9, 3);
      send_item(aiws_pkg::FUNC_INSERT, 13, 9);
      send_item(aiws_pkg::FUNC_INSERT, 4, 14);
      send_item(aiws_pkg::FUNC_INSERT, 5, 126);
      send_item(aiws_pkg::FUNC_INSERT, 5, 127);
      send_item(aiws_pkg::FUNC_INSERT, 5, 255);
      send_item(FUNC_QUERY, 0, 0);
      send_item(FUNC_UNUSED, 32'h7FFF_FFFF, 8'hAA);
      send_item(FUNC_UNUSED, 5, 8'h55);

      // The directed part left 127 entries; one append fills the table.
      send_item(aiws_pkg::FUNC_APPEND, 11, 0);
      send_item(aiws_pkg::FUNC_APPEND, 11, 0);
      send_item(aiws_pkg::FUNC_INSERT, 11, 0);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 2) begin
            req_tvalid <= 0;
            wait_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 40) func = aiws_pkg::FUNC_APPEND;
         else if (r < 80) func = aiws_pkg::FUNC_INSERT;
         else if (r < 95) func = FUNC_QUERY;
         else func = FUNC_UNUSED;
         r = $urandom_range(0, 99);
         if (r < 80) pos = $urandom_range(0, 126);
         else pos = $urandom_range(127, 255);
         send_item(func, pick_value(), pos);
      end

      req_tvalid <= 0;
      hold_ready = 1;
      wait_drained();
      repeat (300) @(posedge clock);
      $display("%0d items sent through append, insert and query, %0d results compared",
               stats_board.items_seen, stats_board.results_seen);
      $display("final fill count %0d, %0d mismatches", stats_board.fill,
               stats_board.mismatches);
      if (stats_board.mismatches == 0 && stats_board.pending_stats.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
